// ----- rtl/fna_pkg.sv -----
package fna_pkg;

    // Radix selection for the shared digit unit.
    typedef logic [1:0] t_radix;
    localparam t_radix RADIX_BIN = 2'd0;
    localparam t_radix RADIX_HEX = 2'd1;
    localparam t_radix RADIX_DEC = 2'd2;

    // Reciprocal of ten, scaled by 2^35, for the 32-bit divide by ten.
    localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    // Conversion letters.
    localparam logic [7:0] CH_LOW_B = 8'h62;  // b
    localparam logic [7:0] CH_LOW_W = 8'h77;  // w
    localparam logic [7:0] CH_UP_P  = 8'h50;  // P
    localparam logic [7:0] CH_LOW_X = 8'h78;  // x
    localparam logic [7:0] CH_UP_X  = 8'h58;  // X
    localparam logic [7:0] CH_LOW_L = 8'h6C;  // l
    localparam logic [7:0] CH_UP_L  = 8'h4C;  // L
    localparam logic [7:0] CH_LOW_D = 8'h64;  // d
    localparam logic [7:0] CH_LOW_U = 8'h75;  // u

    // Characters produced besides digits.
    localparam logic [7:0] CH_ZERO  = 8'h30;  // 0
    localparam logic [7:0] CH_MINUS = 8'h2D;  // -

    // Minimum widths of the padded conversions.
    localparam logic [3:0] MINW_BIN = 4'd2;
    localparam logic [3:0] MINW_W   = 4'd4;
    localparam logic [3:0] MINW_P   = 4'd8;
    localparam logic [3:0] MINW_0   = 4'd0;

    // Lower-case ASCII for one digit value.
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = 8'h30 + {4'h0, d};
        end else begin
            c = 8'h57 + {4'h0, d};
        end
        return c;
    endfunction

endpackage

// ----- rtl/fna_digit_unit.sv -----
module fna_digit_unit (
    input  logic              i_clk,
    input  logic [63:0]       i_val,
    input  fna_pkg::t_radix   i_radix,
    output logic [3:0]        o_digit,
    output logic [63:0]       o_quot
);
    import fna_pkg::*;

    logic [63:0] r_prod;
    logic [28:0] w_q10;
    logic [31:0] w_q10x;

    // Registered product with the reciprocal of ten; valid in the cycle after the value settles.
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_val[31:0]) * 64'(RECIP10);
    end

    // Quotient of the low word by ten, and that quotient times ten.
    assign w_q10  = r_prod[63:RECIP_SHIFT];
    assign w_q10x = {w_q10[28:0], 3'b000} + {2'b00, w_q10[28:0], 1'b0};

    // One digit off the low end of the value, and the value without it.
    always_comb begin
        unique case (i_radix)
            RADIX_BIN: begin
                o_digit = {3'b000, i_val[0]};
                o_quot  = {1'b0, i_val[63:1]};
            end
            RADIX_HEX: begin
                o_digit = i_val[3:0];
                o_quot  = {4'h0, i_val[63:4]};
            end
            RADIX_DEC: begin
                o_digit = 4'(i_val[3:0] - w_q10x[3:0]);
                o_quot  = {35'b0, w_q10};
            end
            default: begin
                o_digit = 4'h0;
                o_quot  = 64'h0;
            end
        endcase
    end

endmodule

// ----- rtl/formatted_number_to_ascii.sv -----
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_mode, i_char_code, i_arg_value
// output    out        o_out_valid / i_out_ready  o_out_char, o_last
//
// One item is handled at a time; o_in_ready is high only while the block is idle.
// A literal or unknown letter is sent as a single character. A conversion first pulls
// its digits onto a stack (d and u wait for the divide-by-ten multiply for each digit),
// then sends the output characters.
// Reset is synchronous and active low; it clears the sequencer and the output valid.
// A stall on the output holds the current character and pauses emission of the next one.
module formatted_number_to_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_mode,
    input  logic [7:0]  i_char_code,
    input  logic [63:0] i_arg_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_char,
    output logic        o_last
);
    import fna_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_DEC1 = 3'd2;
    localparam logic [2:0] S_DEC2 = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;
    localparam logic [2:0] S_LIT  = 3'd5;

    logic [2:0]        r_state, n_state;
    logic              r_ov, n_ov;
    logic [7:0]        r_oc, n_oc;
    logic              r_ol, n_ol;
    logic [7:0]        r_char, n_char;
    logic [63:0]       r_val, n_val;
    t_radix            r_radix, n_radix;
    logic [3:0]        r_minw, n_minw;
    logic              r_neg, n_neg;
    logic [5:0]        r_cnt, n_cnt;
    logic [2:0]        r_pad, n_pad;
    logic [31:0][3:0]  r_stack, n_stack;

    logic [3:0]        w_digit;
    logic [63:0]       w_quot;
    logic              w_out_free;

    fna_digit_unit u_digit (
        .i_clk   (i_clk),
        .i_val   (r_val),
        .i_radix (r_radix),
        .o_digit (w_digit),
        .o_quot  (w_quot)
    );

    assign w_out_free  = !r_ov || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_char  = r_oc;
    assign o_last      = r_ol;

    // Sequencer: decode, digit extraction onto a stack, then emission; literals go straight to emission.
    always_comb begin
        n_state = r_state;
        n_ov    = r_ov && !i_out_ready;
        n_oc    = r_oc;
        n_ol    = r_ol;
        n_char  = r_char;
        n_val   = r_val;
        n_radix = r_radix;
        n_minw  = r_minw;
        n_neg   = r_neg;
        n_cnt   = r_cnt;
        n_pad   = r_pad;
        n_stack = r_stack;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_char = i_char_code;
                    n_val  = {32'h0, i_arg_value[31:0]};
                    n_cnt  = 6'd0;
                    n_neg  = 1'b0;
                    n_minw = MINW_0;
                    n_radix = RADIX_HEX;
                    n_state = S_DIV;
                    if (!i_mode) begin
                        n_state = S_LIT;
                    end else begin
                        unique case (i_char_code)
                            CH_LOW_B: begin
                                n_radix = RADIX_BIN;
                                n_minw  = MINW_BIN;
                            end
                            CH_LOW_W: n_minw = MINW_W;
                            CH_UP_P:  n_minw = MINW_P;
                            CH_LOW_X, CH_UP_X, CH_LOW_L: n_minw = MINW_0;
                            CH_UP_L:  n_val = i_arg_value;
                            CH_LOW_D: begin
                                n_radix = RADIX_DEC;
                                n_state = S_DEC1;
                                if (i_arg_value[31]) begin
                                    n_neg = 1'b1;
                                    n_val = {32'h0, 32'(-i_arg_value[31:0])};
                                end
                            end
                            CH_LOW_U: begin
                                n_radix = RADIX_DEC;
                                n_state = S_DEC1;
                            end
                            default: n_state = S_LIT;
                        endcase
                    end
                end
            end
            S_DEC1: begin
                // Wait for the reciprocal product of the current value.
                n_state = S_DEC2;
            end
            S_DIV, S_DEC2: begin
                n_stack = {r_stack[30:0], w_digit};
                n_val   = w_quot;
                n_cnt   = r_cnt + 6'd1;
                if (w_quot == 64'h0) begin
                    n_state = S_EMIT;
                    if ({2'b00, r_minw} > n_cnt) begin
                        n_pad = 3'({2'b00, r_minw} - n_cnt);
                    end else begin
                        n_pad = 3'd0;
                    end
                end else if (r_radix == RADIX_DEC) begin
                    n_state = S_DEC1;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_ov = 1'b1;
                    priority if (r_pad != 3'd0) begin
                        n_oc  = CH_ZERO;
                        n_ol  = 1'b0;
                        n_pad = r_pad - 3'd1;
                    end else if (r_neg) begin
                        n_oc  = CH_MINUS;
                        n_ol  = 1'b0;
                        n_neg = 1'b0;
                    end else begin
                        n_oc    = digit_char(r_stack[0]);
                        n_ol    = (r_cnt == 6'd1);
                        n_stack = {4'h0, r_stack[31:1]};
                        n_cnt   = r_cnt - 6'd1;
                        if (r_cnt == 6'd1) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_LIT: begin
                // Literal characters and unknown letters go out as they are.
                if (w_out_free) begin
                    n_ov    = 1'b1;
                    n_oc    = r_char;
                    n_ol    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        r_oc    <= n_oc;
        r_ol    <= n_ol;
        r_char  <= n_char;
        r_val   <= n_val;
        r_radix <= n_radix;
        r_minw  <= n_minw;
        r_neg   <= n_neg;
        r_cnt   <= n_cnt;
        r_pad   <= n_pad;
        r_stack <= n_stack;
    end

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
    import fna_pkg::*;

    // One output character as the block should produce it.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_char;

    // One input item waiting to be driven; hold_for_drain makes the driver wait
    // until every expected character of earlier items has come out.
    typedef struct {
        logic        mode;
        logic [7:0]  code;
        logic [63:0] arg;
        bit          hold_for_drain;
    } t_fmt_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_mode = 1'b0;
    logic [7:0]  i_char_code = 8'h00;
    logic [63:0] i_arg_value = 64'h0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_out_char;
    logic        o_last;

    t_fmt_item  pending_items [$];
    t_text_char expected_text [$];
    int         n_issued = 0;
    int         n_accepted = 0;
    int         n_errors = 0;
    int         in_idle_pct = 29;
    int         out_idle_pct = 71;

    formatted_number_to_ascii i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_char_code (i_char_code),
        .i_arg_value (i_arg_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_char  (o_out_char),
        .o_last      (o_last)
    );

    // Clock with a 20-unit period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Work out the characters one item should produce and queue them.
    function automatic void render_item_text(input logic mode, input logic [7:0] code,
                                             input logic [63:0] arg);
        string       hex_glyphs;
        logic [63:0] magnitude;
        logic [63:0] radix;
        logic [63:0] remainder;
        logic [7:0]  digit_text [64];
        int          min_width;
        int          n_digits;
        int          n_pad;
        int          k;
        bit          negative;

        hex_glyphs = "0123456789abcdef";
        magnitude  = {32'h0, arg[31:0]};
        radix      = 64'd16;
        min_width  = 0;
        negative   = 1'b0;
        if (!mode) begin
            expected_text.push_back({code, 1'b1});
            return;
        end
        case (code)
            CH_LOW_B: begin
                radix     = 64'd2;
                min_width = MINW_BIN;
            end
            CH_LOW_W: min_width = MINW_W;
            CH_UP_P:  min_width = MINW_P;
            CH_LOW_X, CH_UP_X, CH_LOW_L: min_width = MINW_0;
            CH_UP_L:  magnitude = arg;
            CH_LOW_D: begin
                radix = 64'd10;
                // The two's complement of the most negative value is itself,
                // which is also the right magnitude.
                if (arg[31]) begin
                    negative  = 1'b1;
                    magnitude = {32'h0, -arg[31:0]};
                end
            end
            CH_LOW_U: radix = 64'd10;
            default: begin
                // Unknown letters are echoed as a single character.
                expected_text.push_back({code, 1'b1});
                return;
            end
        endcase

        // Digits come out least significant first.
        n_digits = 0;
        do begin
            remainder = magnitude % radix;
            digit_text[n_digits] = hex_glyphs[remainder[3:0]];
            n_digits++;
            magnitude = magnitude / radix;
        end while (magnitude != 64'h0);

        n_pad = min_width - (n_digits + negative);
        for (k = 0; k < n_pad; k++) begin
            expected_text.push_back({CH_ZERO, 1'b0});
        end
        if (negative) begin
            expected_text.push_back({CH_MINUS, 1'b0});
        end
        for (k = n_digits - 1; k >= 0; k--) begin
            expected_text.push_back({digit_text[k], 1'b0});
        end
        expected_text[expected_text.size() - 1].last = 1'b1;
    endfunction

    function automatic logic [7:0] conversion_letter(input int idx);
        logic [7:0] letter;
        case (idx)
            0:       letter = CH_LOW_B;
            1:       letter = CH_LOW_W;
            2:       letter = CH_UP_P;
            3:       letter = CH_LOW_X;
            4:       letter = CH_UP_X;
            5:       letter = CH_LOW_L;
            6:       letter = CH_UP_L;
            7:       letter = CH_LOW_D;
            default: letter = CH_LOW_U;
        endcase
        return letter;
    endfunction

    function automatic void add_item(input logic mode, input logic [7:0] code,
                                     input logic [63:0] arg, input bit hold_for_drain);
        t_fmt_item item;
        item.mode           = mode;
        item.code           = code;
        item.arg            = arg;
        item.hold_for_drain = hold_for_drain;
        pending_items.push_back(item);
    endfunction

    // Mostly valid conversions with shaped arguments, some literals and unknown letters.
    task automatic add_random_items(input int count);
        logic [63:0] arg;
        int          n;
        int          pick;
        for (n = 0; n < count; n++) begin
            case ($urandom_range(3))
                0:       arg = {$urandom, 32'h0} | 64'($urandom_range(20));
                1:       arg = {$urandom, 32'hFFFF_FFFF - 32'($urandom_range(3))};
                default: arg = {$urandom, $urandom};
            endcase
            pick = $urandom_range(99);
            if (pick < 15) begin
                add_item(1'b0, 8'($urandom_range(255)), arg, n == 0);
            end else if (pick < 25) begin
                add_item(1'b1, 8'($urandom_range(255)), arg, n == 0);
            end else begin
                add_item(1'b1, conversion_letter($urandom_range(8)), arg,
                         n == 0 || $urandom_range(19) == 0);
            end
        end
    endtask

    task automatic wait_until_quiet();
        while (pending_items.size() != 0 || n_accepted != n_issued
               || expected_text.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Sender: holds each item until its transfer, otherwise idles at random.
    always @(negedge i_clk) begin
        t_fmt_item item;
        if (i_in_valid && n_accepted != n_issued) begin
            // Transfer still pending; payload stays put.
        end else if (i_rst_n && pending_items.size() != 0
                     && $urandom_range(99) >= in_idle_pct
                     && !(pending_items[0].hold_for_drain && expected_text.size() != 0)) begin
            item = pending_items.pop_front();
            i_mode      <= item.mode;
            i_char_code <= item.code;
            i_arg_value <= item.arg;
            i_in_valid  <= 1'b1;
            n_issued++;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Receiver stalls at random.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    // Monitor: predict on each input transfer, check each output transfer.
    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            render_item_text(i_mode, i_char_code, i_arg_value);
            n_accepted++;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_text.size() == 0) begin
                $error("unexpected output character %h", o_out_char);
                n_errors++;
            end else begin
                want = expected_text.pop_front();
                if (o_out_char !== want.ch) begin
                    $error("out_char mismatch: expected %h, actual %h", want.ch, o_out_char);
                    n_errors++;
                end
                if (o_last !== want.last) begin
                    $error("last mismatch: expected %b, actual %b", want.last, o_last);
                    n_errors++;
                end
            end
        end
    end

    // Stimulus sequence and end of run.
    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Literals, including NUL, and unknown letters.
        add_item(1'b0, 8'h00, 64'h0, 1'b0);
        add_item(1'b0, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        add_item(1'b1, "s", 64'h1234, 1'b0);
        add_item(1'b1, "%", 64'h0, 1'b0);
        add_item(1'b1, 8'h00, 64'h0, 1'b0);
        // Zero arguments with padding, padding overflow, ignored upper bits.
        add_item(1'b1, CH_LOW_B, 64'h0, 1'b0);
        add_item(1'b1, CH_LOW_B, 64'h1, 1'b0);
        add_item(1'b1, CH_LOW_B, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        add_item(1'b1, CH_LOW_W, 64'h0, 1'b0);
        add_item(1'b1, CH_LOW_W, 64'h0001_2345, 1'b0);
        add_item(1'b1, CH_UP_P, 64'h5, 1'b0);
        add_item(1'b1, CH_UP_P, 64'hABCD_0000_FFFF_FFFF, 1'b0);
        add_item(1'b1, CH_LOW_X, 64'h1234_5678_DEAD_BEEF, 1'b0);
        add_item(1'b1, CH_UP_X, 64'h0, 1'b0);
        add_item(1'b1, CH_LOW_L, 64'h0000_0000_FFFF_FFFF, 1'b0);
        add_item(1'b1, CH_UP_L, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        add_item(1'b1, CH_UP_L, 64'h0, 1'b0);
        // Signed decimal: most negative, minus one, largest, zero with upper bits.
        add_item(1'b1, CH_LOW_D, 64'h0000_0000_8000_0000, 1'b0);
        add_item(1'b1, CH_LOW_D, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        add_item(1'b1, CH_LOW_D, 64'h0000_0000_7FFF_FFFF, 1'b0);
        add_item(1'b1, CH_LOW_D, 64'hFFFF_FFFF_0000_0000, 1'b0);
        add_item(1'b1, CH_LOW_U, 64'h0000_0000_FFFF_FFFF, 1'b0);
        add_item(1'b1, CH_LOW_U, 64'h8000_0000_0000_0000, 1'b1);

        add_random_items(36);
        wait_until_quiet();

        in_idle_pct  = 71;
        out_idle_pct = 29;
        add_random_items(36);
        wait_until_quiet();

        in_idle_pct  = 0;
        out_idle_pct = 0;
        add_random_items(35);
        wait_until_quiet();

        // Let any stray output show up before the verdict.
        repeat (100) @(posedge i_clk);
        if (n_errors == 0 && expected_text.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
